// ===== src/tli_pkg.sv =====
// Shared types and constants for the table linear interpolator.
// No dependencies; used by every module under src.
package tli_pkg;

  localparam int unsigned ValW  = 32;            // Q16.16 data width
  localparam int unsigned DiffW = ValW + 1;      // width of a difference
  localparam int unsigned ProdW = 2 * DiffW;     // width of a product magnitude
  localparam int unsigned QuoLimW = 40;          // quotient bits that may be kept

  typedef enum logic [0:0] {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    logic        start;
    logic [ProdW-1:0] dividend;
    logic [DiffW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             big;       // quotient does not fit in QuoLimW bits
    logic [QuoLimW:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/tli_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the interpolator.
// Depends on tli_pkg.
module tli_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tli_pkg::div_req_t  req_i,
  output tli_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned PW = tli_pkg::ProdW;
  localparam int unsigned DW = tli_pkg::DiffW;
  localparam int unsigned CntW = $clog2(PW + 1);

  logic [PW-1:0]   quo_q, quo_d;   // shifts dividend out, quotient in
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;
  logic [DW+1:0]   diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], quo_q[PW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = CntW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DW+1]) begin
        rem_d = diff[DW:0];
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.big      = |quo_q[PW-1:tli_pkg::QuoLimW];
  assign rsp_o.quotient = {1'b0, quo_q[tli_pkg::QuoLimW-1:0]};

endmodule

// ===== src/table_linear_interpolator_unit.sv =====
// Top level of the table linear interpolator: table memories, sequencer,
// shared compare/subtract datapath and multiplier. Depends on tli_pkg and tli_divider.
//
// Loads write one (x, y) breakpoint when accepted. A query reads the table one
// entry per cycle through the registered read port: a pass over all points in
// use finds the min/max and the first bracketing segment, StFetch reads the two
// entries of the segment, StDiff forms the differences, StMul the product and
// StDiv starts the divider, and StWait waits for the bit-serial divider to report
// completion. A zero-width segment skips the divider and returns its lower y.
// The result sits in an output register; a new request is accepted only after
// the previous result has been taken. A register write is taken only while the
// block is idle and no request is offered.
module table_linear_interpolator_unit #(
  parameter int unsigned TABLE_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request, from bit 0 up: operation, point_index, point_x, point_y, query_x;
  // bits 103:101 are zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  // Result, from bit 0 up: result_y, segment_used, out_of_range, zero_width,
  // saturated; bit 39 is zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned IdxW = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS) : 1;
  localparam int unsigned VW = tli_pkg::ValW;
  localparam int unsigned DW = tli_pkg::DiffW;
  localparam int unsigned SW = tli_pkg::QuoLimW + 3;  // lower y plus signed quotient

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StScan  = 8'b0000_0010,
    StFetch = 8'b0000_0100,
    StDiff  = 8'b0000_1000,
    StMul   = 8'b0001_0000,
    StDiv   = 8'b0010_0000,
    StWait  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [VW-1:0] x_mem [TABLE_POINTS];
  logic [VW-1:0] y_mem [TABLE_POINTS];
  logic [VW-1:0] xr_q, yr_q;

  logic [4:0] npts_q;
  logic [IdxW:0] n_used;

  logic             in_op;
  logic [3:0]       in_idx;
  logic signed [VW-1:0] in_x, in_y, in_q;
  assign in_op  = s_axis_tdata[0];
  assign in_idx = s_axis_tdata[4:1];
  assign in_x   = s_axis_tdata[36:5];
  assign in_y   = s_axis_tdata[68:37];
  assign in_q   = s_axis_tdata[100:69];

  always_comb begin
    if (npts_q < 5'd2) n_used = (IdxW+1)'(2);
    else if ({{(IdxW+1){1'b0}}, npts_q} > (IdxW+6)'(TABLE_POINTS))
      n_used = (IdxW+1)'(TABLE_POINTS);
    else n_used = (IdxW+1)'(npts_q);
  end

  // Sequencer registers
  logic [IdxW:0]   rd_cnt_q, rd_cnt_d;   // address issued this cycle
  logic [IdxW:0]   chk_q, chk_d;         // index of data in xr_q
  logic [1:0]      fetch_q, fetch_d;
  logic            rvalid_q, rvalid_d;
  logic signed [VW-1:0] q_q, q_d, xmin_q, xmin_d, xmax_q, xmax_d;
  logic signed [VW-1:0] prevx_q, prevx_d;
  logic [IdxW-1:0] seg_q, seg_d;
  logic            found_q, found_d;
  logic signed [VW-1:0] xp_q, xp_d, xn_q, xn_d, yp_q, yp_d, yn_q, yn_d;
  logic signed [DW-1:0] dq_q, dq_d, dy_q, dy_d, dx_q, dx_d;
  logic            neg_q, neg_d;
  logic [tli_pkg::ProdW-1:0] prod_q, prod_d;
  logic [VW-1:0]   res_q, res_d;
  logic            oor_q, oor_d, zw_q, zw_d, sat_q, sat_d;
  logic [IdxW-1:0] rd_addr;

  tli_pkg::div_req_t div_req;
  tli_pkg::div_rsp_t div_rsp;

  tli_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic accept;
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // A request offered in the same cycle goes first, so it sees the old count.
  assign cfg_ready_o   = (state_q == StIdle) && !s_axis_tvalid;

  // Bracketing test of the segment (prev, cur) with the shared subtractors.
  logic signed [DW-1:0] d0, d1;
  logic brk;
  logic signed [SW-1:0] sum_w;
  assign d0  = DW'(q_q) - DW'(prevx_q);
  assign d1  = DW'(q_q) - DW'($signed(xr_q));
  assign brk = (d0 == '0) || (d1 == '0) || (d0[DW-1] != d1[DW-1]);

  always_comb begin
    state_d = state_q; rd_cnt_d = rd_cnt_q; chk_d = chk_q; fetch_d = fetch_q;
    rvalid_d = 1'b0; q_d = q_q; xmin_d = xmin_q; xmax_d = xmax_q;
    prevx_d = prevx_q; seg_d = seg_q; found_d = found_q;
    xp_d = xp_q; xn_d = xn_q; yp_d = yp_q; yn_d = yn_q;
    dq_d = dq_q; dy_d = dy_q; dx_d = dx_q; neg_d = neg_q; prod_d = prod_q;
    res_d = res_q; oor_d = oor_q; zw_d = zw_q; sat_d = sat_q;
    rd_addr = rd_cnt_q[IdxW-1:0];
    div_req.start = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor = $unsigned(dx_q[DW-1] ? -dx_q : dx_q);
    sum_w = '0;
    case (state_q)
      StIdle: begin
        if (accept && in_op == tli_pkg::OpQuery) begin
          q_d = in_q; rd_cnt_d = '0; found_d = 1'b0;
          seg_d = IdxW'(n_used - 2'd2);
          state_d = StScan;
        end
      end
      StScan: begin
        if (rd_cnt_q < n_used) begin
          rd_cnt_d = rd_cnt_q + 1'b1; rvalid_d = 1'b1; chk_d = rd_cnt_q;
        end
        if (rvalid_q) begin
          prevx_d = $signed(xr_q);
          if (chk_q == '0) begin
            xmin_d = $signed(xr_q); xmax_d = $signed(xr_q);
          end else begin
            if ($signed(xr_q) < xmin_q) xmin_d = $signed(xr_q);
            if ($signed(xr_q) > xmax_q) xmax_d = $signed(xr_q);
            if (!found_q && brk) begin
              found_d = 1'b1; seg_d = IdxW'(chk_q - 1'b1);
            end
          end
          if (chk_q == n_used - 1'b1) begin
            state_d = StFetch; fetch_d = '0; rd_cnt_d = '0;
          end
        end
      end
      StFetch: begin
        oor_d = (q_q < xmin_q) || (q_q > xmax_q);
        rd_addr = (fetch_q == 2'd0) ? seg_q : IdxW'(seg_q + 1'b1);
        rd_cnt_d = rd_cnt_q + 1'b1;
        if (rd_cnt_q == (IdxW+1)'(1)) begin
          xp_d = $signed(xr_q); yp_d = $signed(yr_q);
        end
        if (rd_cnt_q == (IdxW+1)'(2)) begin
          xn_d = $signed(xr_q); yn_d = $signed(yr_q); state_d = StDiff;
        end
        fetch_d = 2'd1;
      end
      StDiff: begin
        dq_d = DW'(q_q) - DW'(xp_q);
        dy_d = DW'(yn_q) - DW'(yp_q);
        dx_d = DW'(xn_q) - DW'(xp_q);
        state_d = StMul;
      end
      StMul: begin
        neg_d = (dq_q[DW-1] != dy_q[DW-1]) != dx_q[DW-1];
        prod_d = tli_pkg::ProdW'($unsigned(dq_q[DW-1] ? -dq_q : dq_q))
               * tli_pkg::ProdW'($unsigned(dy_q[DW-1] ? -dy_q : dy_q));
        if (dx_q == '0) begin
          zw_d = 1'b1; sat_d = 1'b0; res_d = yp_q; state_d = StOut;
        end else begin
          zw_d = 1'b0; state_d = StDiv;
        end
      end
      StDiv: begin
        div_req.start = 1'b1; state_d = StWait;
      end
      StWait: begin
        if (div_rsp.done) begin
          if (div_rsp.big) begin
            sat_d = 1'b1; res_d = neg_q ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
          end else begin
            sum_w = SW'(yp_q) + (neg_q ? -SW'($signed({1'b0, div_rsp.quotient})) :
                    SW'($signed({1'b0, div_rsp.quotient})));
            if (sum_w > SW'(32'sh7fffffff)) begin
              sat_d = 1'b1; res_d = 32'h7fffffff;
            end else if (sum_w < -SW'(33'sh080000000)) begin
              sat_d = 1'b1; res_d = 32'h80000000;
            end else begin
              sat_d = 1'b0; res_d = sum_w[VW-1:0];
            end
          end
          state_d = StOut;
        end
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Table memories: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && in_op == tli_pkg::OpLoad && 32'(in_idx) < TABLE_POINTS) begin
      x_mem[IdxW'(in_idx)] <= in_x;
      y_mem[IdxW'(in_idx)] <= in_y;
    end
    xr_q <= x_mem[rd_addr];
    yr_q <= y_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      npts_q   <= 5'd2;
      rd_cnt_q <= '0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
      fetch_q  <= '0;
      chk_q    <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_valid_i && cfg_ready_o) npts_q <= cfg_data_i;
      rd_cnt_q <= rd_cnt_d;
      rvalid_q <= rvalid_d;
      found_q  <= found_d;
      fetch_q  <= fetch_d;
      chk_q    <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; xmin_q <= xmin_d; xmax_q <= xmax_d; prevx_q <= prevx_d;
    seg_q <= seg_d; xp_q <= xp_d; xn_q <= xn_d; yp_q <= yp_d; yn_q <= yn_d;
    dq_q <= dq_d; dy_q <= dy_d; dx_q <= dx_d; neg_q <= neg_d; prod_q <= prod_d;
    res_q <= res_d; oor_q <= oor_d; zw_q <= zw_d; sat_q <= sat_d;
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {1'b0, sat_q, zw_q, oor_q, 4'(seg_q), res_q};

`ifndef SYNTHESIS
  // A zero-width segment never reports saturation.
  a_zw_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(zw_q && sat_q)) else $error("zero width with saturation");
  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StWait) else $error("stray divider completion");
  // A held result stays put until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(res_q)) else $error("result changed");
`endif

endmodule
